// ===== rtl/hasw_pkg.sv =====
package hasw_pkg;

  // Grid and word geometry
  localparam int BLOCKS      = 4;
  localparam int ROWS        = 1024;
  localparam int BLOCK_WIDTH = 256;
  localparam int HALO        = 1;
  localparam int LANES       = 4;
  localparam int ALIGN_GAP   = 3;

  localparam int WORD_W    = 64;
  localparam int ELEMENT_W = 16;
  localparam int ELEM_BITS = WORD_W / LANES;
  localparam int COPY_W    = (ELEM_BITS < ELEMENT_W) ? ELEM_BITS : ELEMENT_W;

  localparam int LANE_W = 3;
  localparam int COL_W  = $clog2(BLOCK_WIDTH + 2 * HALO);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int BLK_W  = $clog2(BLOCKS);

  localparam logic [COL_W-1:0]  EDGE_LAST  = COL_W'(BLOCK_WIDTH + HALO - 1);
  localparam logic [COL_W-1:0]  INNER_LAST = COL_W'(BLOCK_WIDTH + 2 * HALO - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [BLK_W-1:0]  BLK_LAST   = BLK_W'(BLOCKS - 1);
  localparam logic [LANE_W-1:0] LANE_TOP   = LANE_W'(LANES - 1);
  localparam logic [LANE_W-1:0] GAP_LANE   = LANE_W'(ALIGN_GAP & 7);

  // Walker to datapath: lane to pick and whether this element closes the word
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              last;
  } walk_t;

endpackage

// ===== rtl/halo_aware_stream_widener.sv =====
// Latency: a word is captured in the holding register, then its first element goes
//   into the output register; further elements follow one per cycle while not stalled.
// Throughput: a word yields LANES - start lane elements (fewer at a row end), all
//   through the single-element output port, which limits the word rate.
// Reset (synchronous, rst high) clears the column, row, block and lane counters
//   and empties the word holding register and the output register.
module halo_aware_stream_widener import hasw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ELEMENT_W-1:0] element,
  output logic                 last
);

  // Holding register for the word being split up
  logic [WORD_W-1:0] word_q;
  logic              busy;

  walk_t walk;
  logic  emit, accept;

  logic [ELEMENT_W-1:0] lane_elem [LANES];
  logic [ELEMENT_W-1:0] merged;

  // An element is issued whenever a word is held and the output register is
  // free or being drained this cycle.
  assign emit   = busy && (!out_valid || !out_stall);
  // A new word may land on the same edge that issues the old word's final element.
  assign in_stall = busy && !(emit && walk.last);
  assign accept   = in_valid && !in_stall;

  hasw_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .step (emit),
    .walk (walk)
  );

  // One extractor per lane; each drives zero unless it is the selected lane,
  // so a start lane beyond the word reads as zero.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    hasw_lane u_lane (
      .slice    (word_q[g*ELEM_BITS +: ELEM_BITS]),
      .lane_id  (LANE_W'(g)),
      .lane_sel (walk.lane),
      .element  (lane_elem[g])
    );
  end

  // Merge: OR across lanes (at most one is non-zero)
  always_comb begin
    merged = '0;
    for (int i = 0; i < LANES; i++) begin
      merged = merged | lane_elem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (emit && walk.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_q <= word;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      element <= merged;
      last    <= walk.last;
    end
  end

  // A word is only taken over a held one when that one's final element goes out
  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && busy) |-> (emit && walk.last))
    else $error("word taken while previous word still had elements to issue");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !emit)
    else $error("output register overwritten while stalled");

  // After the final element, nothing more is issued until a new word arrives
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit && walk.last && !accept) |=> !busy)
    else $error("still busy after final element of word");

  // The issued last flag matches the walker's end-of-word decision
  a_last_tracks: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && (last == $past(walk.last))))
    else $error("last flag does not follow end-of-word decision");

endmodule

// ===== rtl/hasw_lane.sv =====
module hasw_lane import hasw_pkg::*; (
  input  logic [ELEM_BITS-1:0] slice,
  input  logic [LANE_W-1:0]    lane_id,
  input  logic [LANE_W-1:0]    lane_sel,
  output logic [ELEMENT_W-1:0] element
);

  logic [ELEMENT_W-1:0] value;

  assign value   = ELEMENT_W'(slice[COPY_W-1:0]);
  // Gate to zero unless this lane is selected; the merge ORs all lanes.
  assign element = (lane_sel == lane_id) ? value : '0;

endmodule

// ===== rtl/hasw_walker.sv =====
module hasw_walker import hasw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  output walk_t walk
);

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [BLK_W-1:0]  block_count, block_count_next;
  logic [LANE_W-1:0] lane_index, lane_index_next;

  logic edge_blk, row_end, aligned, top_lane;

  assign edge_blk = (block_count == '0) || (block_count == BLK_LAST);
  assign row_end  = column_count == (edge_blk ? EDGE_LAST : INNER_LAST);
  assign aligned  = ((block_count == '0) && (row_count < ROW_LAST)) ||
                    ((block_count == BLK_LAST) && (row_count == ROW_LAST));
  assign top_lane = lane_index >= LANE_TOP;

  assign walk.lane = lane_index;
  assign walk.last = row_end || top_lane;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    block_count_next  = block_count;
    lane_index_next   = lane_index;
    if (row_end) begin
      column_count_next = '0;
      lane_index_next   = aligned ? '0 : GAP_LANE;
      if (row_count >= ROW_LAST) begin
        row_count_next   = '0;
        block_count_next = (block_count >= BLK_LAST) ? '0 : block_count + 1'b1;
      end else begin
        row_count_next = row_count + 1'b1;
      end
    end else begin
      column_count_next = column_count + 1'b1;
      lane_index_next   = top_lane ? '0 : lane_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      block_count  <= '0;
      lane_index   <= '0;
    end else if (step) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      block_count  <= block_count_next;
      lane_index   <= lane_index_next;
    end
  end

endmodule

// ===== tb/sv/lane_split_checker.sv =====
module lane_split_checker import hasw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_W-1:0]    word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ELEMENT_W-1:0] element,
  input  logic                 last,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PER_WORD = 8;
  localparam int EDGE_END     = BLOCK_WIDTH + HALO - 1;
  localparam int INNER_END    = BLOCK_WIDTH + 2 * HALO - 1;

  typedef struct packed {
    logic [ELEMENT_W-1:0] value;
    logic                 closes;
  } lane_elem_t;

  lane_elem_t        expected_elems[$];
  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [BLK_W-1:0]  blk_pos;
  logic [LANE_W-1:0] lane_pos;
  int                mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // lanes past bit 63 read as zero
  function automatic logic [ELEMENT_W-1:0] lane_field(input logic [WORD_W-1:0] w,
                                                      input logic [LANE_W-1:0] lane);
    int unsigned       shift;
    logic [WORD_W-1:0] v;
    shift = lane * ELEM_BITS;
    if (shift >= WORD_W) return '0;
    v = w >> shift;
    if (ELEM_BITS < WORD_W) v &= (WORD_W'(1) << ELEM_BITS) - WORD_W'(1);
    return v[ELEMENT_W-1:0];
  endfunction

  // walks the grid for one word and queues the elements it yields
  task automatic split_word(input logic [WORD_W-1:0] w);
    int         n;
    bit         done;
    bit         edge_blk;
    bit         row_done;
    bit         aligned;
    lane_elem_t e;
    n    = 0;
    done = 1'b0;
    while (!done && n < MAX_PER_WORD) begin
      e.value  = lane_field(w, lane_pos);
      edge_blk = (blk_pos == '0) || (blk_pos == BLK_W'(BLOCKS - 1));
      row_done = edge_blk ? (col_pos == COL_W'(EDGE_END)) : (col_pos == COL_W'(INNER_END));
      if (row_done) begin
        aligned = (blk_pos == '0 && row_pos < ROW_W'(ROWS - 1)) ||
                  (blk_pos == BLK_W'(BLOCKS - 1) && row_pos == ROW_W'(ROWS - 1));
        col_pos  = '0;
        lane_pos = aligned ? '0 : LANE_W'(ALIGN_GAP & 7);
        if (row_pos >= ROW_W'(ROWS - 1)) begin
          row_pos = '0;
          blk_pos = (blk_pos >= BLK_W'(BLOCKS - 1)) ? '0 : blk_pos + 1'b1;
        end else begin
          row_pos = row_pos + 1'b1;
        end
        done = 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
        if (lane_pos >= LANE_W'(LANES - 1)) begin
          lane_pos = '0;
          done     = 1'b1;
        end else begin
          lane_pos = lane_pos + 1'b1;
        end
      end
      e.closes = done;
      expected_elems.push_back(e);
      n++;
    end
  endtask

  always @(posedge clk) begin
    lane_elem_t got;
    if (rst) begin
      col_pos  = '0;
      row_pos  = '0;
      blk_pos  = '0;
      lane_pos = '0;
      expected_elems.delete();
    end else begin
      // output first: a word never yields an element in its own cycle
      if (out_valid && !out_stall) begin
        if (expected_elems.size() == 0) begin
          report_mismatch($sformatf("element %h last %b with none expected", element, last));
        end else begin
          got = expected_elems.pop_front();
          if (element !== got.value)
            report_mismatch($sformatf("element %h, expected %h", element, got.value));
          if (last !== got.closes)
            report_mismatch($sformatf("last %b, expected %b (element %h)",
                                      last, got.closes, got.value));
        end
      end
      if (in_valid && !in_stall) split_word(word);
    end
    outstanding <= expected_elems.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== tb/sv/halo_aware_stream_widener_tb.sv =====
module halo_aware_stream_widener_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hasw_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int IDLE_PCT     = 10;
  localparam int RANDOM_WORDS = 380;
  // A row of block 0 takes 65 words, so the stretch crosses a row end
  // at full rate.
  localparam int SWEEP_WORDS  = 80;
  localparam int SETTLE_CYCLES = 16;
  // The cycle limit leaves ample headroom over the full run.
  localparam int unsigned CYCLE_LIMIT = 20_000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    word;
  logic                 out_valid;
  logic                 out_stall;
  logic [ELEMENT_W-1:0] element;
  logic                 last;

  int          fail_count;
  int          outstanding;
  bit          steady;        // set for the no-idle stretch on both sides
  int unsigned cycles = 0;

  // Corner words: empty, full, per-lane patterns, single bits at the lane edges.
  logic [WORD_W-1:0] corner_words[$] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555, 64'hFFFF_0000_FFFF_0000,
    64'h0000_FFFF_0000_FFFF, 64'h8000_8000_8000_8000,
    64'h0001_0001_0001_0001, 64'h8000_0000_0000_0000,
    64'h0000_0000_0000_0001, 64'hFEDC_BA98_7654_3210
  };

  halo_aware_stream_widener u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .word     (word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .element  (element),
    .last     (last)
  );

  lane_split_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .word       (word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .element    (element),
    .last       (last),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure: random stalls on about 10 percent of cycles,
  // none at all during the steady stretch.
  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One transaction on the word channel. Outside the steady stretch the
  // sender may first drop valid for a random gap, so gaps land on every
  // phase of the word being split. Valid stays high between back-to-back
  // words; the payload is held until the transaction completes.
  task automatic send_word(input logic [WORD_W-1:0] w);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    word     <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // The checker's count is registered, so look only from the next edge on.
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [WORD_W-1:0] w;
    rst       = 1'b1;
    in_valid  = 1'b0;
    word      = '0;
    steady    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    foreach (corner_words[i]) send_word(corner_words[i]);

    // random words, with a full drain halfway through
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      case ($urandom_range(0, 15))
        0:       w = '0;
        1:       w = '1;
        2:       w = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
        3:       w = ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
        default: w = {$urandom, $urandom};
      endcase
      send_word(w);
    end
    in_valid <= 1'b0;
    wait_drained();

    // steady stretch at full rate
    steady <= 1'b1;
    for (int i = 0; i < SWEEP_WORDS; i++) send_word({$urandom, $urandom});
    in_valid <= 1'b0;
    wait_drained();

    // let any stray element show itself
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
